// ----- sv/sbs_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sorted table binary search: shared types and constants
// Payload words of the three channels, the control word of the sequencer
// and its microcode program.
// -----------------------------------------------------------------------------
package sbs_pkg;

   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 10;

   // opcode field values
   localparam logic OPCODE_WRITE  = 1'b0;
   localparam logic OPCODE_SEARCH = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [INDEX_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] entry_value;
      logic signed [DATA_W-1:0] search_key;
   } req_payload_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
   } csr_payload_type;

   // sequencer steps (microcode addresses)
   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_PROBE,
      STEP_COMPARE,
      STEP_EMIT
   } step_type;

   // jump conditions
   typedef enum logic [1:0] {
      COND_SEARCH,    // search word taken this cycle
      COND_EMPTY,     // range [low, high] is empty
      COND_MATCH,     // probe equals key
      COND_OUT_FREE   // result register can take a word
   } cond_type;

   typedef struct packed {
      logic     take_req;   // raise req ready
      logic     rd_en;      // read table at mid
      logic     cmp_en;     // compare probe, narrow the range
      logic     emit;       // load result register
      cond_type cond;
      step_type jump_to;    // taken when cond holds
      step_type next_step;  // taken otherwise
   } ctrl_word_type;

   // microcode program
   function automatic ctrl_word_type ucode_rom(step_type step);
      ctrl_word_type cw;
      cw = '0;
      unique case (step)
         STEP_IDLE: begin
            cw.take_req  = 1'b1;
            cw.cond      = COND_SEARCH;
            cw.jump_to   = STEP_PROBE;
            cw.next_step = STEP_IDLE;
         end
         STEP_PROBE: begin
            cw.rd_en     = 1'b1;
            cw.cond      = COND_EMPTY;
            cw.jump_to   = STEP_EMIT;
            cw.next_step = STEP_COMPARE;
         end
         STEP_COMPARE: begin
            cw.cmp_en    = 1'b1;
            cw.cond      = COND_MATCH;
            cw.jump_to   = STEP_EMIT;
            cw.next_step = STEP_PROBE;
         end
         STEP_EMIT: begin
            cw.emit      = 1'b1;
            cw.cond      = COND_OUT_FREE;
            cw.jump_to   = STEP_IDLE;
            cw.next_step = STEP_EMIT;
         end
         default: cw = '0;
      endcase
      return cw;
   endfunction

endpackage

// ----- sv/sbs_chan_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Valid/ready channel
// One word moves at a rising edge where valid and ready are both high.
// -----------------------------------------------------------------------------
interface sbs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sorted_table_binary_search_unit.sv -----
`timescale 1ns / 1ps
// Flow: a write word is taken in the idle step and written to the table. A search word
//   runs probe and compare steps until a match or an empty range, then loads the result word.
// Throughput: one search at a time; the next word can be taken in the cycle after the
//   result is loaded, while that result may still wait on rsp ready.
// Each probe is a table read then a compare, set by the registered memory read port.
// Reset clears sequencer, result valid and entry_count; table contents are not cleared.
// -----------------------------------------------------------------------------
// Sorted table binary search unit
// Microcoded sequencer driving a small datapath (low/high bounds, midpoint, table
// memory with one write and one read port, comparator) that binary searches a sorted table.
// -----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   sbs_chan_if.sink    req,
   sbs_chan_if.source  rsp,
   sbs_chan_if.sink    csr
);
   import sbs_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int SW     = CW + 1;

   // table storage
   logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];

   // control
   step_type      step_ff, step_in;
   ctrl_word_type cw;
   logic          cond_hit;

   // datapath registers
   logic [COUNT_W-1:0]       count_ff;
   logic [CW-1:0]            low_ff, low_in;
   logic [CW-1:0]            hi1_ff, hi1_in;   // high + 1
   logic [ADDR_W-1:0]        mid_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff, rsp_data_in;

   logic [CW-1:0]     n_sat;
   logic [SW-1:0]     mid_sum;
   logic [ADDR_W-1:0] mid_addr;
   logic              range_empty;
   logic              probe_match;
   logic              probe_less;
   logic              req_take;
   logic              search_take;
   logic              table_we;
   logic              rd_go;
   logic              out_free;

   // microcode fetch
   assign cw = ucode_rom(step_ff);

   // handshakes
   assign req.ready   = cw.take_req;
   assign csr.ready   = 1'b1;
   assign req_take    = req.valid && cw.take_req;
   assign search_take = req_take && (req.payload.opcode == OPCODE_SEARCH);
   assign table_we    = req_take && (req.payload.opcode == OPCODE_WRITE)
                        && (32'(req.payload.entry_index) < TABLE_DEPTH);
   assign out_free    = !rsp_valid_ff || rsp.ready;

   // saturated entry count
   always_comb begin
      if (32'(count_ff) > TABLE_DEPTH) begin
         n_sat = CW'(TABLE_DEPTH);
      end else begin
         n_sat = CW'(count_ff);
      end
   end

   // midpoint floor((low + high) / 2), valid while range is non-empty
   assign range_empty = (low_ff >= hi1_ff);
   assign mid_sum     = SW'(low_ff) + SW'(hi1_ff) - SW'(1);
   assign mid_addr    = ADDR_W'(mid_sum >> 1);
   assign rd_go       = cw.rd_en && !range_empty;

   // probe compare
   assign probe_match = (rd_data_ff == key_ff);
   assign probe_less  = (rd_data_ff < key_ff);

   // jump condition select
   always_comb begin
      unique case (cw.cond)
         COND_SEARCH:   cond_hit = search_take;
         COND_EMPTY:    cond_hit = range_empty;
         COND_MATCH:    cond_hit = probe_match;
         COND_OUT_FREE: cond_hit = out_free;
         default:       cond_hit = 1'b0;
      endcase
   end

   assign step_in = cond_hit ? cw.jump_to : cw.next_step;

   // bound updates and match capture
   always_comb begin
      low_in   = low_ff;
      hi1_in   = hi1_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      if (search_take) begin
         low_in   = '0;
         hi1_in   = n_sat;
         found_in = 1'b0;
         pos_in   = '0;
      end else if (cw.cmp_en) begin
         priority if (probe_match) begin
            found_in = 1'b1;
            pos_in   = POS_W'(mid_ff);
         end else if (probe_less) begin
            low_in = CW'(mid_ff) + CW'(1);
         end else begin
            hi1_in = CW'(mid_ff);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cw.emit && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.found    = found_ff;
         rsp_data_in.position = pos_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            count_ff <= csr.payload.entry_count;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      low_ff      <= low_in;
      hi1_ff      <= hi1_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      if (search_take) begin
         key_ff <= req.payload.search_key;
      end
      if (rd_go) begin
         mid_ff <= mid_addr;
      end
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (table_we) begin
         table_mem[ADDR_W'(req.payload.entry_index)] <= req.payload.entry_value;
      end
      if (rd_go) begin
         rd_data_ff <= table_mem[mid_addr];
      end
   end

endmodule

// ----- sv/sbs_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sorted table binary search checker
// Port-level assertions, bound to the search unit.
// -----------------------------------------------------------------------------
module sbs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_opcode,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input sbs_pkg::rsp_payload_type rsp_payload
);
   import sbs_pkg::*;

   // a pending result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp word changed while stalled");

   // not-found reports position zero
   a_nf_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.position == '0)
      else $error("not-found result with nonzero position");

   // a search blocks the request side while it runs
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OPCODE_SEARCH) |=> !req_ready)
      else $error("request taken during a search");

   // a search cannot answer in the cycle after it was taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OPCODE_SEARCH) && !rsp_valid
      |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind sorted_table_binary_search_unit sbs_checker u_sbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .req_opcode  (req.payload.opcode),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
